### rtl/psmc_pkg.sv
package psmc_pkg;

    localparam int DATA_W            = 32;
    localparam int DEPTH_W           = 7;
    localparam int MAX_STACK_DEFAULT = 64;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(1);

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [DEPTH_W-1:0]       depth_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_CHECK,
        ST_MEDIAN
    } state_t;

endpackage

### rtl/psmc_store.sv
module psmc_store #(
    parameter int MAX_STACK = psmc_pkg::MAX_STACK_DEFAULT,
    parameter int ADDR_W    = 6
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [ADDR_W-1:0]      waddr,
    input  psmc_pkg::sample_t      wdata,
    input  logic                   re,
    input  logic [ADDR_W-1:0]      raddr,
    output psmc_pkg::sample_t      rdata
);
    import psmc_pkg::*;

    sample_t mem [MAX_STACK];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/psmc_ctrl.sv
module psmc_ctrl #(
    parameter int MAX_STACK = psmc_pkg::MAX_STACK_DEFAULT,
    parameter int ADDR_W    = 6,
    parameter int CNT_W     = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  psmc_pkg::depth_t       cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  psmc_pkg::sample_t      s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output psmc_pkg::sample_t      m_tdata,
    output logic                   mem_we,
    output logic [ADDR_W-1:0]      mem_waddr,
    output psmc_pkg::sample_t      mem_wdata,
    output logic                   mem_re,
    output logic [ADDR_W-1:0]      mem_raddr,
    input  psmc_pkg::sample_t      mem_rdata
);
    import psmc_pkg::*;

    localparam logic [8:0] MAX_9 = 9'(MAX_STACK);

    state_t             state_reg, state_next;
    depth_t             depth_reg, depth_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    sample_t            samp_reg, samp_next;
    logic               out_valid_reg, out_valid_next;
    sample_t            out_data_reg, out_data_next;

    logic [8:0]         depth_9;
    logic [8:0]         n_9;
    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   med_idx;
    logic [CNT_W-1:0]   fill_inc;
    logic [CNT_W-1:0]   fill_m1;
    logic [CNT_W-1:0]   pos_m1;
    logic [CNT_W-1:0]   pos_m2;

    // effective depth: zero counts as one, saturate at the store size
    always_comb
    begin
        depth_9 = {2'b00, depth_reg};
        if (depth_9 == 9'd0)
        begin
            n_9 = 9'd1;
        end
        else if (depth_9 > MAX_9)
        begin
            n_9 = MAX_9;
        end
        else
        begin
            n_9 = depth_9;
        end
    end

    assign n_eff    = CNT_W'(n_9);
    assign med_idx  = (n_eff - CNT_W'(1)) >> 1;
    assign fill_inc = fill_reg + CNT_W'(1);
    assign fill_m1  = fill_reg - CNT_W'(1);
    assign pos_m1   = pos_reg - CNT_W'(1);
    assign pos_m2   = pos_reg - CNT_W'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= DEPTH_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        samp_reg     <= samp_next;
        out_data_reg <= out_data_next;
    end

    // insertion sort into the store: entries above the new sample move up one
    // slot per cycle; reads always go below the slot being written, so no
    // read ever meets a write to the same entry
    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        samp_next      = samp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[ADDR_W-1:0];
        mem_wdata      = samp_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        s_tready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    samp_next = s_tdata;
                    if (fill_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = s_tdata;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = fill_m1[ADDR_W-1:0];
                        pos_next   = fill_reg;
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                mem_we = 1'b1;
                if ($signed(mem_rdata) > $signed(samp_reg))
                begin
                    mem_wdata = mem_rdata;
                    pos_next  = pos_m1;
                    if (pos_reg == CNT_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_m2[ADDR_W-1:0];
                    end
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_PLACE:
            begin
                mem_we     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (fill_inc < n_eff)
                begin
                    fill_next  = fill_inc;
                    state_next = ST_IDLE;
                end
                else
                begin
                    fill_next  = '0;
                    mem_re     = 1'b1;
                    mem_raddr  = med_idx[ADDR_W-1:0];
                    state_next = ST_MEDIAN;
                end
            end
            ST_MEDIAN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mem_rdata;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            depth_next = cfg_wdata;
            fill_next  = '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/pixel_stack_median_combine.sv
// flow: each beat shifts the stored samples above it up one slot and then takes its place;
// the beat that completes a stack is followed by a read of the median from the store,
// and a new beat is accepted only in the idle state, once the last one is placed
// throughput: set by the insertion loop over the sample memory,
// one stored sample moved per cycle
// reset: stack depth 1, fill count zero, no result pending; memory contents are not cleared
module pixel_stack_median_combine #(
    parameter int MAX_STACK = psmc_pkg::MAX_STACK_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  psmc_pkg::depth_t       cfg_wdata,      // stack_depth
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  psmc_pkg::sample_t      s_axis_tdata,   // [31:0] sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output psmc_pkg::sample_t      m_axis_tdata    // [31:0] median_value
);
    import psmc_pkg::*;

    localparam int ADDR_W = (MAX_STACK > 1) ? $clog2(MAX_STACK) : 1;
    localparam int CNT_W  = $clog2(MAX_STACK + 1);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    sample_t           mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    sample_t           mem_rdata;

    psmc_ctrl #(
        .MAX_STACK (MAX_STACK),
        .ADDR_W    (ADDR_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    psmc_store #(
        .MAX_STACK (MAX_STACK),
        .ADDR_W    (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

### verif/pixel_stack_median_combine_tb.sv
module pixel_stack_median_combine_tb;

    import psmc_pkg::*;

    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 5000;

    class median_board;
        sample_t     loaded[$];
        sample_t     medians_due[$];
        int unsigned stack_len;
        int          errors;

        function new();
            stack_len = 1;
            errors    = 0;
        endfunction

        function void set_depth(depth_t d);
            if (d == 0)
                stack_len = 1;
            else if (d > MAX_STACK_DEFAULT)
                stack_len = MAX_STACK_DEFAULT;
            else
                stack_len = d;
            // a depth write throws away any partial stack
            loaded.delete();
        endfunction

        function sample_t lower_median();
            sample_t sorted[$];
            int      pos;
            foreach (loaded[i])
            begin
                pos = 0;
                while (pos < sorted.size() && sorted[pos] <= loaded[i])
                    pos++;
                sorted.insert(pos, loaded[i]);
            end
            return sorted[(sorted.size() - 1) / 2];
        endfunction

        function void note_sample(sample_t s);
            loaded.push_back(s);
            if (loaded.size() == stack_len)
            begin
                medians_due.push_back(lower_median());
                loaded.delete();
            end
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_median(sample_t got);
            sample_t want;
            if (medians_due.size() == 0)
            begin
                report($sformatf("median_value %0d with no stack completed", got));
                return;
            end
            want = medians_due.pop_front();
            if (got !== want)
                report($sformatf("median_value got %0d want %0d", got, want));
        endtask

        function int pending();
            return medians_due.size();
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    cfg_we;
    depth_t  cfg_wdata;
    logic    s_axis_tvalid;
    logic    s_axis_tready;
    sample_t s_axis_tdata;    // [31:0] sample
    logic    m_axis_tvalid;
    logic    m_axis_tready;
    sample_t m_axis_tdata;    // [31:0] median_value

    median_board board;
    int          tx_idle_pct = 12;
    int          rx_idle_pct = 72;
    bit          hold_req    = 1'b0;
    int          items_sent  = 0;
    int          quiet_cycles = 0;

    pixel_stack_median_combine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(negedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_median(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // called and returns at a falling edge
    task send_sample(sample_t v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_sample(v);
        items_sent++;
        @(negedge clk);
    endtask

    task write_depth(depth_t d);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        // a trailing partial stack may still be inserting
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_depth(d);
    endtask

    function sample_t pick_sample();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return sample_t'($urandom);
        else if (r < 80)
            return sample_t'(int'($urandom_range(8)) - 4);    // dense ties
        else if (r < 90)
        begin
            case ($urandom_range(3))
                0: return sample_t'(32'h8000_0000);
                1: return sample_t'(32'h7FFF_FFFF);
                2: return sample_t'(0);
                default: return sample_t'(-1);
            endcase
        end
        else if (r < 95)
            return sample_t'(32'h8000_0000 + $urandom_range(3));
        else
            return sample_t'(32'h7FFF_FFFF - $urandom_range(3));
    endfunction

    task set_idle_mode();
        if (items_sent < 500)
        begin
            tx_idle_pct = 12;
            rx_idle_pct = 72;
        end
        else if (items_sent < 1000)
        begin
            tx_idle_pct = 72;
            rx_idle_pct = 12;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    depth_t phase_depth[14] = '{1, 2, 3, 5, 4, 64, 7, 0, 16, 127, 9, 33, 2, 1};
    int     phase_items[14] = '{90, 90, 90, 90, 90, 130, 90, 90, 90, 140, 90, 80, 90, 120};

    initial
    begin
        int count;
        board         = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // depth after reset is one: every beat is its own median
        send_sample(sample_t'(32'h8000_0000));
        send_sample(sample_t'(32'h7FFF_FFFF));
        send_sample(sample_t'(0));
        send_sample(sample_t'(-1));
        // depth zero behaves as one
        write_depth(depth_t'(0));
        send_sample(sample_t'(5));
        send_sample(sample_t'(-5));
        write_depth(depth_t'(3));
        send_sample(sample_t'(-1));
        send_sample(sample_t'(32'h8000_0000));
        send_sample(sample_t'(32'h7FFF_FFFF));
        send_sample(sample_t'(7));
        send_sample(sample_t'(7));
        send_sample(sample_t'(-3));
        // even depth picks the lower of the two middle values
        write_depth(depth_t'(2));
        send_sample(sample_t'(32'h7FFF_FFFF));
        send_sample(sample_t'(32'h8000_0000));
        send_sample(sample_t'(4));
        send_sample(sample_t'(4));
        // partial stack, then dropped by the next depth write
        write_depth(depth_t'(4));
        send_sample(sample_t'(10));
        send_sample(sample_t'(1));
        write_depth(depth_t'(5));
        for (int k = 9; k >= 5; k--)
            send_sample(sample_t'(k));

        foreach (phase_depth[p])
        begin
            write_depth(phase_depth[p]);
            if (p == 13)
                hold_req = 1'b1;
            count = phase_items[p] + $urandom_range(15);
            repeat (count)
            begin
                set_idle_mode();
                send_sample(pick_sample());
            end
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.pending() != 0)
            board.report($sformatf("%0d medians never arrived", board.pending()));
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### pixel_stack_median_combine.f
rtl/psmc_pkg.sv
rtl/psmc_store.sv
rtl/psmc_ctrl.sv
rtl/pixel_stack_median_combine.sv
verif/pixel_stack_median_combine_tb.sv
